@@ hdl/olide_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Field widths, operation codes and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package olide_pkg;

    localparam int OP_W   = 3;
    localparam int POS_W  = 8;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;

    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE   = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_VAL = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_POS = 3'd4;

    localparam logic signed [WORD_W-1:0] FAIL_WORD = -32'sd1;
    localparam logic [CNT_W-1:0]         CAP_RESET = 5'd5;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_UPDATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic [POS_W-1:0]          slot;
        logic [CNT_W-1:0]          count;
        logic signed [WORD_W-1:0]  value;
    } cell_ctrl_t;

endpackage

@@ hdl/olide_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry, shifts with its neighbours and compares against the
// search word.
// ----------------------------------------------------------------------------
module olide_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                               clk,
    input  olide_pkg::cell_ctrl_t              ctrl,
    input  logic signed [olide_pkg::WORD_W-1:0] left_word,
    input  logic signed [olide_pkg::WORD_W-1:0] right_word,
    input  logic                               hit_in,
    output logic signed [olide_pkg::WORD_W-1:0] word,
    output logic                               hit_out,
    output logic                               first_hit
);
    import olide_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(CELL_INDEX);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic [POS_W-1:0]         count_ext;
    logic                     match;

    assign count_ext = {{(POS_W-CNT_W){1'b0}}, ctrl.count};

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (IDX == ctrl.slot)
                begin
                    word_next = ctrl.value;
                end
                else if (IDX > ctrl.slot)
                begin
                    word_next = left_word;
                end
            end
            CMD_DELETE:
            begin
                if (IDX >= ctrl.slot)
                begin
                    word_next = right_word;
                end
            end
            CMD_UPDATE:
            begin
                if (IDX == ctrl.slot)
                begin
                    word_next = ctrl.value;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign match     = (IDX < count_ext) && (word_reg == ctrl.value);
    assign word      = word_reg;
    assign hit_out   = hit_in | match;
    assign first_hit = match & ~hit_in;

endmodule

@@ hdl/ordered_list_insert_delete_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list insert and delete engine
// Keeps an ordered list of signed words in a row of cells and serves insert,
// delete, update, find by value and find by position requests.
// ----------------------------------------------------------------------------
// Response: the result is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle while results are taken; each insert or
// delete shifts the cells at and above its slot together, so the next item sees its effect.
// Reset: list length clears to zero and capacity_limit loads five; the entry
// cells are left undefined and only entries below the length are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_engine #(
    parameter int STORE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [olide_pkg::CNT_W-1:0]         cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [olide_pkg::OP_W-1:0]          operation,
    input  logic [olide_pkg::POS_W-1:0]         position,
    input  logic signed [olide_pkg::WORD_W-1:0] value,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic                                status,
    output logic signed [olide_pkg::WORD_W-1:0] data_out,
    output logic [olide_pkg::CNT_W-1:0]         found_position,
    output logic [olide_pkg::CNT_W-1:0]         list_length
);
    import olide_pkg::*;

    localparam logic [POS_W-1:0] DEPTH_P = POS_W'(STORE_DEPTH);

    logic [CNT_W-1:0]         capacity_limit_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic                     status_reg;
    logic                     status_next;
    logic signed [WORD_W-1:0] data_out_reg;
    logic signed [WORD_W-1:0] data_out_next;
    logic [CNT_W-1:0]         found_reg;
    logic [CNT_W-1:0]         found_next;

    logic                     accept;
    logic [POS_W-1:0]         count_ext;
    logic [POS_W-1:0]         cap_ext;
    logic [POS_W-1:0]         cap;
    logic                     pos_ok;
    logic                     ins_ok;
    cell_cmd_t                cmd;
    cell_ctrl_t               ctrl;
    logic signed [WORD_W-1:0] read_word;
    logic [CNT_W-1:0]         hit_position;

    logic signed [WORD_W-1:0] cell_word [STORE_DEPTH];
    logic                     hit_chain [STORE_DEPTH+1];
    logic                     first_hit [STORE_DEPTH];

    assign cfg_ready = 1'b1;
    assign req_ready = ~rsp_valid_reg | rsp_ready;
    assign accept    = req_valid & req_ready;

    assign count_ext = {{(POS_W-CNT_W){1'b0}}, count_reg};
    assign cap_ext   = {{(POS_W-CNT_W){1'b0}}, capacity_limit_reg};
    assign cap       = (cap_ext < DEPTH_P) ? cap_ext : DEPTH_P;
    assign pos_ok    = (position != '0) && (position <= count_ext);
    assign ins_ok    = (position != '0) && (position <= count_ext + POS_W'(1))
                       && (position <= cap) && (count_ext < cap);

    assign ctrl.cmd   = accept ? cmd : CMD_HOLD;
    assign ctrl.slot  = position - POS_W'(1);
    assign ctrl.count = count_reg;
    assign ctrl.value = value;

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        olide_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_word  ((i == 0) ? value : cell_word[(i == 0) ? 0 : i - 1]),
            .right_word (cell_word[(i == STORE_DEPTH - 1) ? i : i + 1]),
            .hit_in     (hit_chain[i]),
            .word       (cell_word[i]),
            .hit_out    (hit_chain[i+1]),
            .first_hit  (first_hit[i])
        );
    end

    always_comb
    begin
        read_word    = '0;
        hit_position = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (ctrl.slot == POS_W'(i))
            begin
                read_word = read_word | cell_word[i];
            end
            if (first_hit[i])
            begin
                hit_position = hit_position | CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        cmd           = CMD_HOLD;
        status_next   = 1'b1;
        data_out_next = '0;
        found_next    = '0;
        count_next    = count_reg;
        case (operation)
            OP_INSERT:
            begin
                if (ins_ok)
                begin
                    cmd         = CMD_INSERT;
                    status_next = 1'b0;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (pos_ok)
                begin
                    cmd           = CMD_DELETE;
                    status_next   = 1'b0;
                    data_out_next = read_word;
                    count_next    = count_reg - CNT_W'(1);
                end
                else
                begin
                    data_out_next = FAIL_WORD;
                end
            end
            OP_UPDATE:
            begin
                if (pos_ok)
                begin
                    cmd         = CMD_UPDATE;
                    status_next = 1'b0;
                end
            end
            OP_FIND_VAL:
            begin
                status_next = 1'b0;
                found_next  = hit_position;
            end
            OP_FIND_POS:
            begin
                if (pos_ok)
                begin
                    status_next   = 1'b0;
                    data_out_next = read_word;
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_limit_reg <= CAP_RESET;
            count_reg          <= '0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_limit_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            data_out_reg <= data_out_next;
            found_reg    <= found_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign data_out       = data_out_reg;
    assign found_position = found_reg;
    assign list_length    = count_reg;

`ifndef SYNTHESIS
    a_count_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= DEPTH_P)
    else $error("List length exceeds the store depth.");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_INSERT && ins_ok)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
    else $error("Accepted insert did not grow the list by one.");

    a_failed_delete: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_DELETE && !pos_ok)
        |=> (data_out_reg == FAIL_WORD && status_reg))
    else $error("Rejected delete did not return the failure word.");

    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (found_reg <= count_reg))
    else $error("Found position lies beyond the list length.");
`endif

endmodule

@@ sim/list_response_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list response checker
// Watches the configuration, request and response channels of the ordered
// list engine. It keeps its own copy of the list and the capacity limit,
// works out the response to every accepted request item, and compares each
// accepted response item field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module list_response_checker #(
    parameter int STORE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [olide_pkg::CNT_W-1:0]         cfg_data,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic [olide_pkg::OP_W-1:0]          operation,
    input  logic [olide_pkg::POS_W-1:0]         position,
    input  logic signed [olide_pkg::WORD_W-1:0] value,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic                                status,
    input  logic signed [olide_pkg::WORD_W-1:0] data_out,
    input  logic [olide_pkg::CNT_W-1:0]         found_position,
    input  logic [olide_pkg::CNT_W-1:0]         list_length,
    output int                                  mismatches,
    output int                                  awaited_count
);

    import olide_pkg::*;

    typedef struct packed {
        logic                     status;
        logic signed [WORD_W-1:0] data;
        logic [CNT_W-1:0]         found;
        logic [CNT_W-1:0]         length;
    } list_response_t;

    logic signed [WORD_W-1:0] entry_words [STORE_DEPTH];
    int                       entry_total;
    logic [CNT_W-1:0]         cap_limit;
    list_response_t           awaited_responses [$];

    initial
    begin
        mismatches    = 0;
        awaited_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("ERROR at %0t ns: %s is %h, expected %h", $realtime, what, seen, wanted);
        mismatches++;
    endtask

    task automatic apply_list_request(input logic [OP_W-1:0] op,
                                      input logic [POS_W-1:0] pos,
                                      input logic signed [WORD_W-1:0] word,
                                      output list_response_t res);
        int limit;
        int slot;
        int idx;
        slot       = pos;
        res.status = 1'b1;
        res.data   = '0;
        res.found  = '0;
        limit      = (cap_limit < STORE_DEPTH) ? cap_limit : STORE_DEPTH;
        case (op)
            OP_INSERT:
            begin
                if (slot != 0 && slot <= entry_total + 1 && slot <= limit
                    && entry_total < limit)
                begin
                    for (idx = entry_total; idx >= slot; idx--)
                        entry_words[idx] = entry_words[idx-1];
                    entry_words[slot-1] = word;
                    entry_total++;
                    res.status = 1'b0;
                end
            end
            OP_DELETE:
            begin
                if (slot != 0 && slot <= entry_total)
                begin
                    res.data = entry_words[slot-1];
                    for (idx = slot; idx < entry_total; idx++)
                        entry_words[idx-1] = entry_words[idx];
                    entry_total--;
                    res.status = 1'b0;
                end
                else
                begin
                    res.data = FAIL_WORD;
                end
            end
            OP_UPDATE:
            begin
                if (slot != 0 && slot <= entry_total)
                begin
                    entry_words[slot-1] = word;
                    res.status = 1'b0;
                end
            end
            OP_FIND_VAL:
            begin
                res.status = 1'b0;
                for (idx = 0; idx < entry_total; idx++)
                begin
                    if (entry_words[idx] == word)
                    begin
                        res.found = CNT_W'(idx + 1);
                        break;
                    end
                end
            end
            OP_FIND_POS:
            begin
                if (slot != 0 && slot <= entry_total)
                begin
                    res.data   = entry_words[slot-1];
                    res.status = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        res.length = CNT_W'(entry_total);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_response_t want;
        if (!rst_n)
        begin
            entry_total = 0;
            cap_limit   = CAP_RESET;
            awaited_responses.delete();
            awaited_count <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    report_mismatch("response item with none awaited, list_length",
                                    32'(list_length), 32'd0);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (data_out !== want.data)
                        report_mismatch("data_out", data_out, want.data);
                    if (found_position !== want.found)
                        report_mismatch("found_position", 32'(found_position),
                                        32'(want.found));
                    if (list_length !== want.length)
                        report_mismatch("list_length", 32'(list_length), 32'(want.length));
                end
            end
            if (req_valid && req_ready)
            begin
                apply_list_request(operation, position, value, want);
                awaited_responses.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                cap_limit = cfg_data;
            awaited_count <= awaited_responses.size();
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives a short directed sequence and then phases of random request items
// under several capacity limits, with random gaps on both channels, a long
// response hold-off and drains between phases. The checker beside the block
// predicts and compares every response item.
// ----------------------------------------------------------------------------
module tb;

    import olide_pkg::*;

    localparam int DEPTH       = 16;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 175;
    localparam int LONG_HOLD   = 300;
    localparam int LIMIT       = 400000;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data  = '0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    logic [OP_W-1:0]          operation = '0;
    logic [POS_W-1:0]         position  = '0;
    logic signed [WORD_W-1:0] value     = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    logic                     status;
    logic signed [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]         found_position;
    logic [CNT_W-1:0]         list_length;

    int mismatches;
    int awaited_count;
    int observed_length = 0;
    int rsp_wait        = 0;
    int cycle_count     = 0;
    bit rsp_steady      = 1'b0;
    bit hold_request    = 1'b0;

    int phase_caps [PHASES] = '{16, 1, 31, 0, 16, 3, 8, 2, 16, 5};
    int phase_ins  [PHASES] = '{70, 50, 75, 40, 85, 35, 50, 50, 45, 55};

    always #5 clk = ~clk;

    ordered_list_insert_delete_engine #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .operation(operation),
        .position(position),
        .value(value),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .data_out(data_out),
        .found_position(found_position),
        .list_length(list_length)
    );

    list_response_checker #(
        .STORE_DEPTH(DEPTH)
    ) response_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .operation(operation),
        .position(position),
        .value(value),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .data_out(data_out),
        .found_position(found_position),
        .list_length(list_length),
        .mismatches(mismatches),
        .awaited_count(awaited_count)
    );

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [OP_W-1:0] pick_operation(input int insert_pct);
        int r;
        if ($urandom_range(0, 99) < insert_pct)
            return OP_INSERT;
        r = $urandom_range(0, 99);
        if (r < 35)
            return OP_DELETE;
        if (r < 55)
            return OP_UPDATE;
        if (r < 75)
            return OP_FIND_VAL;
        if (r < 96)
            return OP_FIND_POS;
        case ($urandom_range(0, 2))
            0:       return OP_SPARE_A;
            1:       return OP_SPARE_B;
            default: return OP_SPARE_C;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 15)
            return POS_W'($urandom_range(0, 255));
        return POS_W'($urandom_range(1, observed_length + 1));
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        int r;
        int near;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            near = $urandom_range(0, 7);
            return near - 4;
        end
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [WORD_W-1:0] word, input bit steady);
        int gap;
        gap = draw_gap(steady);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= word;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic write_capacity(input int cap);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(cap);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        do @(posedge clk); while (awaited_count != 0);
    endtask

    // The response side draws its own stall for every item and serves the
    // long hold-off when one is asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                observed_length = list_length;
                rsp_wait        = draw_gap(rsp_steady);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_wait     = LONG_HOLD;
            end
            if (rsp_wait > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_wait--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int  ph;
        int  n;
        bit  steady;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the capacity limit left by reset.
        send_request(OP_FIND_VAL, 8'd0,   32'sd0,       1'b0);
        send_request(OP_FIND_POS, 8'd1,   32'sd0,       1'b0);
        send_request(OP_DELETE,   8'd1,   32'sd0,       1'b0);
        send_request(OP_UPDATE,   8'd1,   32'sd7,       1'b0);
        send_request(OP_INSERT,   8'd0,   32'sd9,       1'b0);
        send_request(OP_INSERT,   8'd2,   32'sd9,       1'b0);
        send_request(OP_INSERT,   8'd1,   WORD_MIN,     1'b0);
        send_request(OP_INSERT,   8'd2,   WORD_MAX,     1'b1);
        send_request(OP_INSERT,   8'd1,   -32'sd1,      1'b1);
        send_request(OP_INSERT,   8'd2,   32'sd0,       1'b0);
        send_request(OP_INSERT,   8'd5,   32'h5555_5555, 1'b0);
        send_request(OP_INSERT,   8'd3,   32'sd11,      1'b0);
        send_request(OP_INSERT,   8'd6,   32'sd12,      1'b0);
        send_request(OP_FIND_VAL, 8'd0,   WORD_MAX,     1'b1);
        send_request(OP_FIND_VAL, 8'd255, 32'sd12345,   1'b0);
        send_request(OP_FIND_POS, 8'd0,   32'sd0,       1'b0);
        send_request(OP_FIND_POS, 8'd5,   32'sd0,       1'b1);
        send_request(OP_FIND_POS, 8'd6,   32'sd0,       1'b0);
        send_request(OP_UPDATE,   8'd3,   32'hAAAA_AAAA, 1'b0);
        send_request(OP_UPDATE,   8'd0,   32'sd1,       1'b0);
        send_request(OP_UPDATE,   8'd255, 32'sd1,       1'b0);
        send_request(OP_DELETE,   8'd0,   32'sd0,       1'b0);
        send_request(OP_DELETE,   8'd255, 32'sd0,       1'b0);
        send_request(OP_DELETE,   8'd5,   32'sd0,       1'b1);
        send_request(OP_SPARE_A,  8'd1,   32'sd1,       1'b0);
        send_request(OP_SPARE_B,  8'd1,   32'sd1,       1'b0);
        send_request(OP_SPARE_C,  8'd1,   32'sd1,       1'b0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_capacity(phase_caps[ph]);
            steady     = (ph == 1 || ph == 4);
            rsp_steady = steady;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 4 && n == 40)
                    hold_request = 1'b1;
                send_request(pick_operation(phase_ins[ph]), pick_position(), pick_word(),
                             steady);
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && awaited_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
